// File: design/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg: shared definitions for the ADC temperature averager
// Widths, constants, the controller state type and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ata_pkg;

  localparam int CODE_W       = 10;
  localparam int READING_W    = 16;
  localparam int TEMP_W       = 19;
  localparam int HIST_DEPTH   = 5;
  localparam int SUM_W        = READING_W + $clog2(HIST_DEPTH + 1);

  localparam int DIV_W        = 22;
  localparam int DIVISOR_W    = 10;
  localparam int DIV_STEPS    = DIV_W / 2;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [DIV_W-1:0]  RECIP_NUM  = DIV_W'(2830 * 691);
  localparam logic [TEMP_W-1:0] KNEE_POINT = TEMP_W'(3000);

  // The knee slope 42/10 is applied as 21/5, which gives the same floor.
  localparam int KNEE_PROD_W  = 21;
  localparam logic [KNEE_PROD_W-1:0] KNEE_MUL = KNEE_PROD_W'(21);
  localparam logic [DIVISOR_W-1:0]   KNEE_DIV = DIVISOR_W'(5);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REC_GO,
    ST_REC_RUN,
    ST_HIST,
    ST_AVG_GO,
    ST_AVG_RUN,
    ST_KNEE,
    ST_KNEE_GO,
    ST_KNEE_RUN,
    ST_KNEE_FIX,
    ST_OUTPUT
  } state_t;

  typedef enum logic [1:0] {
    DIV_RECIP,
    DIV_AVG,
    DIV_KNEE
  } div_op_t;

  typedef struct packed {
    logic    capture;
    logic    div_start;
    div_op_t div_op;
    logic    store_reading;
    logic    store_avg;
    logic    store_knee;
    logic    load_out;
  } ata_cmd_t;

  typedef struct packed {
    logic div_done;
    logic above_knee;
    logic out_free;
  } ata_sts_t;

endpackage

// File: design/adc_temperature_averager.sv
// ----------------------------------------------------------------------------
// adc_temperature_averager: averaged temperature from sensor ADC codes
// Each item takes a reciprocal division, a history update and an averaging
// division, plus a knee correction when the average is at or above the knee.
// A new item is taken only once the last one is loaded into the output register;
// it makes up to three passes through the shared divider at two bits per cycle.
// Reset clears the controller, the output valid flag and the history.
// ----------------------------------------------------------------------------
module adc_temperature_averager (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ata_pkg::CODE_W-1:0]    adc_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ata_pkg::TEMP_W-1:0]    temperature,
  output logic [ata_pkg::READING_W-1:0] latest_reading
);
  import ata_pkg::*;

  ata_cmd_t cmd;
  ata_sts_t sts;

  ata_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ata_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .adc_code       (adc_code),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .temperature    (temperature),
    .latest_reading (latest_reading)
  );

endmodule

// File: design/ata_div.sv
// ----------------------------------------------------------------------------
// ata_div: iterative unsigned divider
// Restoring division, two quotient bits per cycle. The divisor is held from
// the start pulse; the quotient is valid in the cycle after done.
// ----------------------------------------------------------------------------
module ata_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ata_pkg::DIV_W-1:0]     dividend,
  input  logic [ata_pkg::DIVISOR_W-1:0] divisor,
  output logic                          done,
  output logic [ata_pkg::DIV_W-1:0]     quotient
);
  import ata_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W-1:0] rem;
  logic [DIV_W-1:0]     acc;

  logic [DIVISOR_W:0]   trial_a, diff_a, trial_b, diff_b;
  logic [DIVISOR_W-1:0] rem_a, rem_next;
  logic                 q_a, q_b;

  always_comb begin
    trial_a  = {rem, acc[DIV_W-1]};
    diff_a   = trial_a - {1'b0, dsr};
    q_a      = (trial_a >= {1'b0, dsr});
    rem_a    = q_a ? diff_a[DIVISOR_W-1:0] : trial_a[DIVISOR_W-1:0];
    trial_b  = {rem_a, acc[DIV_W-2]};
    diff_b   = trial_b - {1'b0, dsr};
    q_b      = (trial_b >= {1'b0, dsr});
    rem_next = q_b ? diff_b[DIVISOR_W-1:0] : trial_b[DIVISOR_W-1:0];
  end

  assign done     = busy && (cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + DIV_CNT_W'(1);
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= '0;
      acc <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      acc <= {acc[DIV_W-3:0], q_a, q_b};
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("Divider started while a division was in progress.");

endmodule

// File: design/ata_dp.sv
// ----------------------------------------------------------------------------
// ata_dp: datapath of the ADC temperature averager
// Holds the captured code, the reading history with its running sum, the
// shared divider, the averaged temperature and the output register.
// ----------------------------------------------------------------------------
module ata_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ata_pkg::CODE_W-1:0]    adc_code,
  input  ata_pkg::ata_cmd_t             cmd,
  output ata_pkg::ata_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ata_pkg::TEMP_W-1:0]    temperature,
  output logic [ata_pkg::READING_W-1:0] latest_reading
);
  import ata_pkg::*;

  logic [CODE_W-1:0]      code_q;
  logic [READING_W-1:0]   hist [HIST_DEPTH];
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       hist_total;
  logic [TEMP_W-1:0]      avg_q;
  logic [READING_W-1:0]   excess;
  logic [KNEE_PROD_W-1:0] knee_prod;
  logic [DIV_W-1:0]       div_dividend;
  logic [DIVISOR_W-1:0]   div_divisor;
  logic                   div_done;
  logic [DIV_W-1:0]       quotient;

  always_comb begin
    excess    = READING_W'(avg_q - KNEE_POINT);
    knee_prod = KNEE_PROD_W'(excess) * KNEE_MUL;
    case (cmd.div_op)
      DIV_RECIP: begin
        div_dividend = RECIP_NUM;
        div_divisor  = (code_q == '0) ? DIVISOR_W'(1) : DIVISOR_W'(code_q);
      end
      DIV_AVG: begin
        div_dividend = DIV_W'(sum);
        div_divisor  = DIVISOR_W'(HIST_DEPTH);
      end
      DIV_KNEE: begin
        div_dividend = DIV_W'(knee_prod);
        div_divisor  = KNEE_DIV;
      end
      default: begin
        div_dividend = RECIP_NUM;
        div_divisor  = DIVISOR_W'(1);
      end
    endcase
  end

  ata_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_q <= adc_code;
    end
  end

  // History and running sum: the sum always equals the total of the entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
      sum <= '0;
    end else if (cmd.store_reading) begin
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist[i] <= hist[i-1];
      end
      hist[0] <= quotient[READING_W-1:0];
      sum     <= sum + SUM_W'(quotient[READING_W-1:0]) - SUM_W'(hist[HIST_DEPTH-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_avg) begin
      avg_q <= TEMP_W'(quotient);
    end else if (cmd.store_knee) begin
      avg_q <= KNEE_POINT + TEMP_W'(quotient);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      temperature    <= avg_q;
      latest_reading <= hist[0];
    end
  end

  always_comb begin
    hist_total = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_total = hist_total + SUM_W'(hist[i]);
    end
  end

  assign sts.div_done   = div_done;
  assign sts.above_knee = (quotient >= DIV_W'(KNEE_POINT));
  assign sts.out_free   = !out_valid || out_ready;

  a_sum_tracks: assert property (@(posedge clk) disable iff (rst) sum == hist_total)
    else $error("Running sum differs from the total of the history.");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("Output register loaded over an item not yet taken.");

  a_knee_range: assert property (@(posedge clk) disable iff (rst)
    cmd.store_knee |-> (avg_q >= KNEE_POINT))
    else $error("Knee correction applied to an average below the knee.");

endmodule

// File: design/ata_ctrl.sv
// ----------------------------------------------------------------------------
// ata_ctrl: controller of the ADC temperature averager
// Sequences the reciprocal division, the history update, the averaging
// division, the optional knee correction and the output load.
// ----------------------------------------------------------------------------
module ata_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output ata_pkg::ata_cmd_t cmd,
  input  ata_pkg::ata_sts_t sts
);
  import ata_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_REC_GO;
        end
      end
      ST_REC_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_RECIP;
        state_next    = ST_REC_RUN;
      end
      ST_REC_RUN: begin
        if (sts.div_done) begin
          state_next = ST_HIST;
        end
      end
      ST_HIST: begin
        cmd.store_reading = 1'b1;
        state_next        = ST_AVG_GO;
      end
      ST_AVG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_AVG;
        state_next    = ST_AVG_RUN;
      end
      ST_AVG_RUN: begin
        if (sts.div_done) begin
          state_next = ST_KNEE;
        end
      end
      ST_KNEE: begin
        cmd.store_avg = 1'b1;
        state_next    = sts.above_knee ? ST_KNEE_GO : ST_OUTPUT;
      end
      ST_KNEE_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_KNEE;
        state_next    = ST_KNEE_RUN;
      end
      ST_KNEE_RUN: begin
        if (sts.div_done) begin
          state_next = ST_KNEE_FIX;
        end
      end
      ST_KNEE_FIX: begin
        cmd.store_knee = 1'b1;
        state_next     = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == ST_REC_RUN || state == ST_AVG_RUN || state == ST_KNEE_RUN))
    else $error("Divider finished outside a division wait state.");

endmodule
